### design/rau_pkg.sv
// Package: shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned DefWidth = 32;

  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_CMP  = 3'd4,
    KIND_NORM = 3'd5,
    KIND_NEG  = 3'd6,
    KIND_NONE = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_OVF  = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL1, S_MUL2, S_ADD, S_GCD_SHIFT, S_GCD_STRIP, S_GCD_LOOP,
    S_GCD_FIX, S_DIV_N, S_DIV_D, S_EMIT, S_DONE
  } state_e;

  // Command from the sequencer to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

### design/rau_div.sv
// Shared restoring divider: one quotient bit per cycle over 64 bits.
`timescale 1ns / 1ps
module rau_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t rsp_o
);

  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 64'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### design/rau_core.sv
// Sequencer: load, exact cross products, signed sum or compare, binary GCD, reduce, range check.
`timescale 1ns / 1ps
module rau_core #(
  parameter int unsigned Width = rau_pkg::DefWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rau_pkg::in_item_t   item_i,
  output logic                done_o,
  output rau_pkg::out_item_t  res_o,
  output rau_pkg::div_req_t   div_req_o,
  input  rau_pkg::div_rsp_t   div_rsp_i
);

  localparam logic [63:0] Lim = 64'd1 << (Width - 1);

  rau_pkg::state_e state_q, state_d;
  logic [2:0]  kind_q, kind_d;
  logic        an_q, an_d, bn_q, bn_d;
  logic [32:0] am_q, am_d, ad_q, ad_d, bm_q, bm_d, bd_q, bd_d;
  // shared 33x33 multiplier operands and products
  logic [63:0] p1_q, p1_d, p2_q, p2_d;
  logic        rn_q, rn_d;
  logic [63:0] n_q, n_d, d_q, d_d;
  logic [63:0] gx_q, gx_d, gy_q, gy_d;
  logic [6:0]  gk_q, gk_d;
  logic [63:0] g_q, g_d;
  rau_pkg::out_item_t res_q, res_d;
  logic        done_d;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic        zden;

  function automatic logic [32:0] mag(input logic [31:0] v);
    return v[31] ? 33'(33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
  endfunction

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    an_d = an_q; bn_d = bn_q;
    am_d = am_q; ad_d = ad_q; bm_d = bm_q; bd_d = bd_q;
    p1_d = p1_q; p2_d = p2_q;
    rn_d = rn_q; n_d = n_q; d_d = d_q;
    gx_d = gx_q; gy_d = gy_q; gk_d = gk_q; g_d = g_q;
    res_d  = res_q;
    done_d = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    div_req_o = '0;
    zden = 1'b0;

    case (state_q)
      rau_pkg::S_IDLE: begin
        if (start_i) begin
          kind_d = item_i.kind;
          am_d = mag(item_i.a_num);
          ad_d = mag(item_i.a_den);
          bm_d = mag(item_i.b_num);
          bd_d = mag(item_i.b_den);
          an_d = (item_i.a_num != '0) && (item_i.a_num[31] != item_i.a_den[31]);
          bn_d = (item_i.b_num != '0) && (item_i.b_num[31] != item_i.b_den[31]);
          state_d = rau_pkg::S_LOAD;
        end
      end
      rau_pkg::S_LOAD: begin
        res_d = '0;
        zden = (ad_q == '0) ||
               ((kind_q inside {[rau_pkg::KIND_ADD:rau_pkg::KIND_CMP]}) && bd_q == '0) ||
               (kind_q == rau_pkg::KIND_DIV && bm_q == '0);
        if (kind_q == rau_pkg::KIND_NONE) begin
          state_d = rau_pkg::S_DONE;
        end else if (zden) begin
          res_d.status = rau_pkg::ST_ZDEN;
          state_d = rau_pkg::S_DONE;
        end else begin
          // first product: numerator side
          case (kind_q)
            rau_pkg::KIND_MUL: begin mul_a = am_q; mul_b = bm_q; end
            rau_pkg::KIND_NORM, rau_pkg::KIND_NEG: begin mul_a = am_q; mul_b = 33'd1; end
            default: begin mul_a = am_q; mul_b = bd_q; end
          endcase
          p1_d = mul_p[63:0];
          state_d = rau_pkg::S_MUL1;
        end
      end
      rau_pkg::S_MUL1: begin
        mul_a = bm_q;
        mul_b = ad_q;
        p2_d = mul_p[63:0];
        state_d = rau_pkg::S_MUL2;
      end
      rau_pkg::S_MUL2: begin
        // denominator product
        case (kind_q)
          rau_pkg::KIND_DIV: begin mul_a = ad_q; mul_b = bm_q; end
          rau_pkg::KIND_NORM, rau_pkg::KIND_NEG: begin mul_a = ad_q; mul_b = 33'd1; end
          default: begin mul_a = ad_q; mul_b = bd_q; end
        endcase
        d_d = mul_p[63:0];
        state_d = rau_pkg::S_ADD;
      end
      rau_pkg::S_ADD: begin
        case (kind_q)
          rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
            if (an_q == (bn_q ^ (kind_q == rau_pkg::KIND_SUB))) begin
              n_d = p1_q + p2_q; rn_d = an_q;
            end else if (p1_q >= p2_q) begin
              n_d = p1_q - p2_q; rn_d = an_q;
            end else begin
              n_d = p2_q - p1_q; rn_d = bn_q ^ (kind_q == rau_pkg::KIND_SUB);
            end
          end
          rau_pkg::KIND_MUL, rau_pkg::KIND_DIV: begin n_d = p1_q; rn_d = an_q ^ bn_q; end
          rau_pkg::KIND_NEG: begin n_d = p1_q; rn_d = (am_q != '0) && !an_q; end
          default: begin n_d = p1_q; rn_d = an_q; end
        endcase
        if (kind_q == rau_pkg::KIND_CMP) begin
          // signed compare of cross products
          res_d.is_less    = ({an_q, bn_q} == 2'b10) ||
                             (!an_q && !bn_q && p1_q < p2_q) ||
                             (an_q && bn_q && p1_q > p2_q);
          res_d.is_equal   = (an_q == bn_q || (p1_q == '0 && p2_q == '0)) && p1_q == p2_q;
          res_d.is_greater = !res_d.is_less && !res_d.is_equal;
          state_d = rau_pkg::S_DONE;
        end else begin
          state_d = rau_pkg::S_GCD_SHIFT;
        end
      end
      rau_pkg::S_GCD_SHIFT: begin
        if (n_q == '0) begin
          rn_d = 1'b0; n_d = '0; d_d = 64'd1;
          state_d = rau_pkg::S_EMIT;
        end else begin
          gx_d = n_q; gy_d = d_q; gk_d = '0;
          state_d = rau_pkg::S_GCD_STRIP;
        end
      end
      rau_pkg::S_GCD_STRIP: begin
        // remove common factors of two, then make x odd
        if (!gx_q[0] && !gy_q[0]) begin
          gx_d = gx_q >> 1; gy_d = gy_q >> 1; gk_d = gk_q + 7'd1;
        end else if (!gx_q[0]) begin
          gx_d = gx_q >> 1;
        end else begin
          state_d = rau_pkg::S_GCD_LOOP;
        end
      end
      rau_pkg::S_GCD_LOOP: begin
        if (!gy_q[0]) begin
          gy_d = gy_q >> 1;
        end else if (gx_q > gy_q) begin
          gx_d = gy_q; gy_d = gx_q - gy_q;
        end else begin
          gy_d = gy_q - gx_q;
        end
        if (gy_q[0] && gx_q == gy_q) state_d = rau_pkg::S_GCD_FIX;
      end
      rau_pkg::S_GCD_FIX: begin
        g_d = gx_q << gk_q[5:0];
        div_req_o.start = 1'b1;
        div_req_o.dividend = n_q;
        div_req_o.divisor  = gx_q << gk_q[5:0];
        state_d = rau_pkg::S_DIV_N;
      end
      rau_pkg::S_DIV_N: begin
        if (div_rsp_i.done) begin
          n_d = div_rsp_i.quotient;
          div_req_o.start = 1'b1;
          div_req_o.dividend = d_q;
          div_req_o.divisor  = g_q;
          state_d = rau_pkg::S_DIV_D;
        end
      end
      rau_pkg::S_DIV_D: begin
        if (div_rsp_i.done) begin
          d_d = div_rsp_i.quotient;
          state_d = rau_pkg::S_EMIT;
        end
      end
      rau_pkg::S_EMIT: begin
        if ((rn_q ? n_q > Lim : n_q > Lim - 64'd1) || d_q > Lim - 64'd1) begin
          res_d.status = rau_pkg::ST_OVF;
        end else begin
          res_d.res_num = rn_q ? 32'(64'd0 - n_q) : n_q[31:0];
          res_d.res_den = d_q[30:0];
          res_d.status  = rau_pkg::ST_OK;
        end
        state_d = rau_pkg::S_DONE;
      end
      rau_pkg::S_DONE: begin
        done_d = 1'b1;
        state_d = rau_pkg::S_IDLE;
      end
      default: state_d = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    an_q <= an_d; bn_q <= bn_d;
    am_q <= am_d; ad_q <= ad_d; bm_q <= bm_d; bd_q <= bd_d;
    p1_q <= p1_d; p2_q <= p2_d;
    rn_q <= rn_d; n_q <= n_d; d_q <= d_d;
    gx_q <= gx_d; gy_q <= gy_d; gk_q <= gk_d; g_q <= g_d;
    res_q <= res_d;
  end

  assign done_o = done_d;
  assign res_o  = res_q;

endmodule

### design/rational_arithmetic_unit.sv
// Top level: rational arithmetic unit with input handshake and output register.
`timescale 1ns / 1ps
// Channel  Direction  Payload      Handshake
// in       input      in_item_t    in_valid_i / in_stall_o
// out      output     out_item_t   out_valid_o / out_stall_i
//
// One item at a time. An item runs through the binary GCD steps and two passes
// through the shared restoring divider; compare, zero denominator and unused
// kinds skip both.
// Reset clears the sequencer, divider control and the output valid.
// A result sits in the output register while out_stall_i is high; the next
// item is taken only once that register is free.
module rational_arithmetic_unit #(
  parameter int unsigned Width = rau_pkg::DefWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rau_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rau_pkg::out_item_t out_item_o
);

  logic               busy_q, busy_d;
  logic               ovalid_q, ovalid_d;
  rau_pkg::out_item_t oitem_q;
  logic               start;
  logic               core_done;
  rau_pkg::out_item_t core_res;
  rau_pkg::div_req_t  div_req;
  rau_pkg::div_rsp_t  div_rsp;

  // Hold off new items while one is in flight or a result waits.
  assign in_stall_o = busy_q || ovalid_q;
  assign start      = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d   = busy_q;
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (start) busy_d = 1'b1;
    if (core_done) begin
      busy_d   = 1'b0;
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Capture the finished result; it holds until taken.
  always_ff @(posedge clk_i) begin
    if (core_done) oitem_q <= core_res;
  end

  rau_core #(.Width(Width)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .item_i    (in_item_i),
    .done_o    (core_done),
    .res_o     (core_res),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = ovalid_q;
  assign out_item_o  = oitem_q;

endmodule

### test/rational_arithmetic_unit_checker.sv
// Checker: predicts rational unit results from accepted items and compares them.
`timescale 1ns / 1ps
module rational_arithmetic_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  rau_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  rau_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned W = rau_pkg::DefWidth;

  rau_pkg::out_item_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    int k;
    k = 0;
    if (x == 0) return y;
    if (y == 0) return x;
    while (((x | y) & 64'd1) == 0) begin
      x >>= 1;
      y >>= 1;
      k++;
    end
    while (x[0] == 1'b0) x >>= 1;
    do begin
      while (y[0] == 1'b0) y >>= 1;
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y -= x;
    end while (y != 0);
    return x << k;
  endfunction

  function automatic logic [63:0] magnitude(logic [31:0] v, output logic neg);
    neg = v[31];
    return neg ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  // Reduce n/d, apply sign and range check.
  function automatic void reduce_into(logic neg, logic [63:0] n, logic [63:0] d,
                                      ref rau_pkg::out_item_t r);
    logic [63:0] g, lim;
    lim = 64'd1 << (W - 1);
    g = gcd64(n, d);
    n = n / g;
    d = d / g;
    if (n == 0) begin
      neg = 1'b0;
      d = 1;
    end
    if ((neg ? n > lim : n > lim - 1) || d > lim - 1) begin
      r.status = rau_pkg::ST_OVF;
      return;
    end
    r.res_num = neg ? (32'd0 - n[31:0]) : n[31:0];
    r.res_den = d[30:0];
    r.status = rau_pkg::ST_OK;
  endfunction

  function automatic rau_pkg::out_item_t rational_result(rau_pkg::in_item_t it);
    rau_pkg::out_item_t r;
    logic an, bn, nn, dn, rn;
    logic [63:0] am, ad, bm, bd, x, y, rm;
    logic signed [63:0] l, rr;
    rau_pkg::kind_e k;
    r = '0;
    k = rau_pkg::kind_e'(it.kind);
    am = magnitude(it.a_num, nn);
    ad = magnitude(it.a_den, dn);
    an = (am != 0) && (nn != dn);
    bm = magnitude(it.b_num, nn);
    bd = magnitude(it.b_den, dn);
    bn = (bm != 0) && (nn != dn);
    if (k == rau_pkg::KIND_NONE) return r;
    if (ad == 0 || (it.kind <= rau_pkg::KIND_CMP && bd == 0)) begin
      r.status = rau_pkg::ST_ZDEN;
      return r;
    end
    case (k)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
        x = am * bd;
        y = bm * ad;
        nn = (k == rau_pkg::KIND_SUB) ? !bn : bn;
        if (an == nn) begin
          rn = an;
          rm = x + y;
        end else if (x >= y) begin
          rn = an;
          rm = x - y;
        end else begin
          rn = nn;
          rm = y - x;
        end
        if (rm == 0) rn = 1'b0;
        if (bm == 0 && k == rau_pkg::KIND_SUB) rn = (rm != 0) && an;
        reduce_into(rn, rm, ad * bd, r);
      end
      rau_pkg::KIND_MUL: reduce_into(an != bn, am * bm, ad * bd, r);
      rau_pkg::KIND_DIV: begin
        if (bm == 0) r.status = rau_pkg::ST_ZDEN;
        else reduce_into(an != bn, am * bd, ad * bm, r);
      end
      rau_pkg::KIND_CMP: begin
        l = (an ? -$signed(am) : $signed(am)) * $signed(bd);
        rr = (bn ? -$signed(bm) : $signed(bm)) * $signed(ad);
        r.is_less = l < rr;
        r.is_equal = l == rr;
        r.is_greater = l > rr;
      end
      rau_pkg::KIND_NORM: reduce_into(an, am, ad, r);
      default: reduce_into(am != 0 && !an, am, ad, r);
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rau_pkg::out_item_t e;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(rational_result(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_item_i) begin
            $display("%0t: expected %p actual %p", $time, e, out_item_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### test/rational_arithmetic_unit_test.sv
// Testbench top: drives items into the rational unit and reports the verdict.
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;

  localparam int StallLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  rau_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rau_pkg::out_item_t out_item_o;
  int                 fail_count, pending;
  int                 send_idle_pct, recv_idle_pct;
  int                 quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rational_arithmetic_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  rational_arithmetic_unit_checker checker_inst (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: stall at random, at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("rational_arithmetic_unit: mismatch");
      $finish;
    end
  end

  // Mostly small operands so reductions and sums stay in range; some full range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(15) - 8;
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $urandom_range(2000) - 1000;
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    if ($urandom_range(40) == 0) return 32'd0;
    if ($urandom_range(10) == 0) return pick_value();
    return $urandom_range(1) ? $urandom_range(1000, 1) : $urandom_range(60, 1);
  endfunction

  // Present one item, hold it until accepted, idle after it at random.
  task automatic send_item(rau_pkg::kind_e k, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    in_item_i <= '{kind: k, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
      @(negedge clk_i);
    end
  endtask

  task automatic send_random();
    send_item(rau_pkg::kind_e'($urandom_range(7)), pick_value(), pick_den(),
              pick_value(), pick_den());
  endtask

  initial begin
    send_idle_pct = 12;
    recv_idle_pct = 76;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: every kind, extremes, zero denominators, negative denominators.
    send_item(rau_pkg::KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(rau_pkg::KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_item(rau_pkg::KIND_SUB, -32'sd3, 32'd4, 32'd0, 32'd5);
    send_item(rau_pkg::KIND_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_item(rau_pkg::KIND_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_item(rau_pkg::KIND_DIV, 32'd3, 32'd5, 32'd0, 32'd7);
    send_item(rau_pkg::KIND_DIV, 32'd3, 32'd5, -32'sd9, 32'd10);
    send_item(rau_pkg::KIND_CMP, 32'd1, 32'd3, 32'd2, 32'd6);
    send_item(rau_pkg::KIND_CMP, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
    send_item(rau_pkg::KIND_CMP, 32'd5, 32'd1, -32'sd5, 32'd1);
    send_item(rau_pkg::KIND_NORM, 32'd6, -32'sd4, 32'd0, 32'd0);
    send_item(rau_pkg::KIND_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
    send_item(rau_pkg::KIND_NORM, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
    send_item(rau_pkg::KIND_NORM, 32'd1, 32'h8000_0000, 32'd0, 32'd1);
    send_item(rau_pkg::KIND_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
    send_item(rau_pkg::KIND_NEG, 32'd0, -32'sd7, 32'd0, 32'd1);
    send_item(rau_pkg::KIND_NEG, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    send_item(rau_pkg::KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(rau_pkg::KIND_ADD, 32'd1, 32'd1, 32'd1, 32'd0);
    send_item(rau_pkg::KIND_NORM, 32'd1, 32'd3, 32'd1, 32'd0);
    send_item(rau_pkg::KIND_NONE, 32'd5, 32'd3, 32'd1, 32'd2);
    send_item(rau_pkg::KIND_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    for (int n = 0; n < 600; n++) send_random();
    send_idle_pct = 76;
    recv_idle_pct = 12;
    for (int n = 0; n < 600; n++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 600; n++) send_random();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("rational_arithmetic_unit: match");
    else $display("rational_arithmetic_unit: mismatch");
    $finish;
  end
endmodule
